### rtl/tq_pkg.sv
// tq_pkg: shared types and constants of the team queue.
// Used by tq_front, tq_back, team_queue, tq_checker and the sim files; no dependencies.
`default_nettype none

package tq_pkg;

  localparam int TQ_TEAMS       = 16;
  localparam int TQ_TEAM_BITS   = 4;
  localparam int TQ_ORDER_BITS  = 5;
  localparam int TQ_VALUE_BITS  = 16;
  localparam int TQ_CAPACITY    = 1024;

  typedef enum logic {
    OP_ENQ,
    OP_DEQ
  } tq_op_t;

  typedef enum logic [1:0] {
    STATUS_DONE,
    STATUS_EMPTY,
    STATUS_FULL
  } tq_status_t;

  typedef enum logic {
    BK_ISSUE,
    BK_FINISH
  } tq_state_t;

  typedef struct packed {
    logic                     mode;
    logic [TQ_TEAM_BITS-1:0]  team;
    logic [TQ_VALUE_BITS-1:0] value;
  } tq_in_t;

  typedef struct packed {
    tq_op_t                   op;
    logic [TQ_TEAM_BITS-1:0]  team;
    logic [TQ_VALUE_BITS-1:0] value;
  } tq_cmd_t;

  typedef struct packed {
    tq_status_t               status;
    logic [TQ_TEAM_BITS-1:0]  out_team;
    logic [TQ_VALUE_BITS-1:0] out_value;
    logic                     now_empty;
  } tq_out_t;

  typedef struct packed {
    logic valid;
  } tq_cmd_hs_t;

endpackage

`default_nettype wire

### rtl/tq_ram.sv
// tq_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module tq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                             clk,
  input  wire logic                             wr_en,
  input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                 wr_data,
  input  wire logic                             rd_en,
  input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                 rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/tq_fifo.sv
// tq_fifo: two-entry register FIFO with show-ahead read.
// No dependencies.
`default_nettype none

module tq_fifo #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  empty
);

  logic [WIDTH-1:0] mem [2];
  logic             wp;
  logic             rp;
  logic [1:0]       count;
  logic             do_wr;
  logic             do_rd;

  assign full    = count == 2'd2;
  assign empty   = count == 2'd0;
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_wr) begin
        wp <= ~wp;
      end
      if (do_rd) begin
        rp <= ~rp;
      end
      if (do_wr && !do_rd) begin
        count <= count + 2'd1;
      end else if (do_rd && !do_wr) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wp] <= wr_data;
    end
  end

endmodule

`default_nettype wire

### rtl/tq_front.sv
// tq_front: accepts input transactions, decodes them into commands, queues them.
// Depends on tq_pkg and tq_fifo.
`default_nettype none

module tq_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire tq_pkg::tq_in_t    item,
  output tq_pkg::tq_cmd_hs_t     hs_valid,
  input  wire logic              cmd_pop,
  output tq_pkg::tq_cmd_t        cmd
);
  import tq_pkg::*;

  tq_cmd_t                decoded;
  logic [$bits(tq_cmd_t)-1:0] fifo_out;
  logic                   fifo_empty;

  always_comb begin
    decoded.op    = item.mode ? OP_DEQ : OP_ENQ;
    decoded.team  = item.mode ? '0 : item.team;
    decoded.value = item.mode ? '0 : item.value;
  end

  tq_fifo #(
    .WIDTH($bits(tq_cmd_t))
  ) u_cmd_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (decoded),
    .full    (full),
    .rd_en   (cmd_pop),
    .rd_data (fifo_out),
    .empty   (fifo_empty)
  );

  assign cmd            = tq_cmd_t'(fifo_out);
  assign hs_valid.valid = !fifo_empty;

endmodule

`default_nettype wire

### rtl/tq_back.sv
// tq_back: executes enqueue/dequeue commands on the pooled per-team linked lists.
// Depends on tq_pkg and tq_ram.
`default_nettype none

module tq_back #(
  parameter int CAPACITY = tq_pkg::TQ_CAPACITY
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire tq_pkg::tq_cmd_hs_t hs_valid,
  input  wire tq_pkg::tq_cmd_t    cmd_in,
  output logic                    cmd_pop,
  input  wire logic               res_full,
  output logic                    res_push,
  output tq_pkg::tq_out_t         res
);
  import tq_pkg::*;

  localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  tq_state_t                 state;
  tq_state_t                 state_next;
  tq_cmd_t                   cmd;

  logic [SW-1:0]             team_head [TQ_TEAMS];
  logic [SW-1:0]             team_tail [TQ_TEAMS];
  logic [TQ_TEAMS-1:0]       team_waiting;
  logic [TQ_TEAM_BITS-1:0]   order_ring [TQ_TEAMS];
  logic [TQ_TEAM_BITS-1:0]   order_read;
  logic [TQ_TEAM_BITS-1:0]   order_write;
  logic [TQ_ORDER_BITS-1:0]  order_count;
  logic [CW-1:0]             fresh_count;
  logic [SW-1:0]             free_head;
  logic [CW-1:0]             free_count;
  logic [CW-1:0]             used_count;
  logic [CW-1:0]             used_next;

  logic [TQ_TEAM_BITS-1:0]   front_team;
  logic [SW-1:0]             front_head;
  logic                      front_last;
  logic [SW-1:0]             rd_addr;
  logic                      rd_en;
  logic [SW-1:0]             link_rdata;
  logic [TQ_VALUE_BITS-1:0]  value_rdata;

  logic                      pool_full;
  logic                      order_empty;
  logic                      from_free;
  logic [SW-1:0]             slot_new;
  logic                      enq_waiting;
  logic                      do_enq;
  logic                      do_deq;
  logic                      link_wr_en;
  logic [SW-1:0]             link_wr_addr;
  logic [SW-1:0]             link_wr_data;

  assign front_team  = order_ring[order_read];
  assign front_head  = team_head[front_team];
  assign front_last  = front_head == team_tail[front_team];

  assign pool_full   = used_count == CW'(CAPACITY);
  assign order_empty = order_count == '0;
  assign from_free   = free_count != '0;
  assign slot_new    = from_free ? free_head : fresh_count[SW-1:0];
  assign enq_waiting = team_waiting[cmd.team];

  assign do_enq = (state == BK_FINISH) && (cmd.op == OP_ENQ) && !pool_full;
  assign do_deq = (state == BK_FINISH) && (cmd.op == OP_DEQ) && !order_empty;

  assign link_wr_en   = (do_enq && enq_waiting) || do_deq;
  assign link_wr_addr = do_enq ? team_tail[cmd.team] : front_head;
  assign link_wr_data = do_enq ? slot_new : free_head;

  always_comb begin
    state_next = state;
    case (state)
      BK_ISSUE: begin
        if (hs_valid.valid && !res_full) begin
          state_next = BK_FINISH;
        end
      end
      BK_FINISH: state_next = BK_ISSUE;
      default:   state_next = BK_ISSUE;
    endcase
  end

  always_comb begin
    cmd_pop  = 1'b0;
    res_push = 1'b0;
    rd_en    = 1'b0;
    case (state)
      BK_ISSUE: begin
        cmd_pop = hs_valid.valid && !res_full;
        rd_en   = cmd_pop;
      end
      BK_FINISH: res_push = 1'b1;
      default: ;
    endcase
  end

  assign rd_addr = (cmd_in.op == OP_ENQ) ? free_head : front_head;

  always_comb begin
    used_next = used_count;
    if (do_enq) begin
      used_next = used_count + CW'(1);
    end else if (do_deq) begin
      used_next = used_count - CW'(1);
    end
  end

  always_comb begin
    res.status    = STATUS_DONE;
    res.out_team  = '0;
    res.out_value = '0;
    res.now_empty = used_next == '0;
    if (cmd.op == OP_ENQ) begin
      if (pool_full) begin
        res.status = STATUS_FULL;
      end
    end else if (order_empty) begin
      res.status = STATUS_EMPTY;
    end else begin
      res.out_team  = front_team;
      res.out_value = value_rdata;
    end
  end

  tq_ram #(
    .WIDTH (TQ_VALUE_BITS),
    .DEPTH (CAPACITY)
  ) u_value_ram (
    .clk     (clk),
    .wr_en   (do_enq),
    .wr_addr (slot_new),
    .wr_data (cmd.value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (value_rdata)
  );

  tq_ram #(
    .WIDTH (SW),
    .DEPTH (CAPACITY)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (link_wr_en),
    .wr_addr (link_wr_addr),
    .wr_data (link_wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (link_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= BK_ISSUE;
      team_waiting <= '0;
      order_read   <= '0;
      order_write  <= '0;
      order_count  <= '0;
      fresh_count  <= '0;
      free_head    <= '0;
      free_count   <= '0;
      used_count   <= '0;
    end else begin
      state      <= state_next;
      used_count <= used_next;
      if (do_enq) begin
        if (from_free) begin
          free_head  <= link_rdata;
          free_count <= free_count - CW'(1);
        end else begin
          fresh_count <= fresh_count + CW'(1);
        end
        if (!enq_waiting) begin
          team_waiting[cmd.team] <= 1'b1;
          order_write            <= order_write + TQ_TEAM_BITS'(1);
          order_count            <= order_count + TQ_ORDER_BITS'(1);
        end
      end
      if (do_deq) begin
        free_head  <= front_head;
        free_count <= free_count + CW'(1);
        if (front_last) begin
          team_waiting[front_team] <= 1'b0;
          order_read               <= order_read + TQ_TEAM_BITS'(1);
          order_count              <= order_count - TQ_ORDER_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cmd <= cmd_in;
    end
    if (do_enq) begin
      team_tail[cmd.team] <= slot_new;
      if (!enq_waiting) begin
        team_head[cmd.team]     <= slot_new;
        order_ring[order_write] <= cmd.team;
      end
    end
    if (do_deq && !front_last) begin
      team_head[front_team] <= link_rdata;
    end
  end

endmodule

`default_nettype wire

### rtl/team_queue.sv
// team_queue: top level of the team queue.
// Depends on tq_pkg, tq_front, tq_back, tq_fifo.
//
//   channel   handshake        payload
//   input     push / full      item   (mode, team, value)
//   result    pop / empty      result (status, out_team, out_value, now_empty)
//
// In the execution unit BK_ISSUE reads the pool link/value RAMs, then BK_FINISH
// writes them back and updates the list pointers. On its way a transaction passes
// the input queue, the command and RAM read registers, and the result queue.
// Two-entry queues on input and result let each side stall independently.
// rst is synchronous; it empties both queues and the pool, no clearing pass.
`default_nettype none

module team_queue #(
  parameter int CAPACITY = tq_pkg::TQ_CAPACITY
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  output logic                 full,
  input  wire tq_pkg::tq_in_t  item,
  output logic                 empty,
  input  wire logic            pop,
  output tq_pkg::tq_out_t      result
);
  import tq_pkg::*;

  tq_cmd_hs_t                 hs_valid;
  tq_cmd_t                    cmd;
  logic                       cmd_pop;
  logic                       res_full;
  logic                       res_push;
  tq_out_t                    res;
  logic [$bits(tq_out_t)-1:0] res_q;

  tq_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .hs_valid (hs_valid),
    .cmd_pop  (cmd_pop),
    .cmd      (cmd)
  );

  tq_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .hs_valid (hs_valid),
    .cmd_in   (cmd),
    .cmd_pop  (cmd_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res)
  );

  tq_fifo #(
    .WIDTH ($bits(tq_out_t))
  ) u_res_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_q),
    .empty   (empty)
  );

  assign result = tq_out_t'(res_q);

endmodule

`default_nettype wire

### rtl/tq_checker.sv
// tq_checker: port-level assertions for team_queue, bound to the top level.
// Depends on tq_pkg and team_queue.
`default_nettype none

module tq_checker (
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            full,
  input wire logic            empty,
  input wire logic            pop,
  input wire tq_pkg::tq_out_t result
);
  import tq_pkg::*;

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> empty ##1 empty)
    else $error("result shown too soon after reset");

  a_reset_open: assert property (@(posedge clk)
    rst |=> !full)
    else $error("input blocked right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(result))
    else $error("stalled result changed");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    !empty && (result.status == STATUS_EMPTY || result.status == STATUS_FULL)
    |-> result.out_team == '0 && result.out_value == '0)
    else $error("failed transaction carries data");

  a_full_not_empty: assert property (@(posedge clk) disable iff (rst)
    !empty && result.status == STATUS_FULL |-> !result.now_empty)
    else $error("pool full reported with nothing queued");

endmodule

bind team_queue tq_checker u_tq_checker (
  .clk    (clk),
  .rst    (rst),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);

`default_nettype wire

### sim/team_queue_chk.sv
// team_queue_chk: watches both queue channels of team_queue, predicts each
// result from its own copy of the team lists and compares field by field.
// Depends on tq_pkg.
module team_queue_chk
  import tq_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  logic    full,
  input  tq_in_t  item,
  input  logic    empty,
  input  logic    pop,
  input  tq_out_t result,
  output int      errors,
  output int      pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOT_BITS = $clog2(TQ_CAPACITY);

  logic [TQ_VALUE_BITS-1:0] slot_val  [TQ_CAPACITY];
  logic [SLOT_BITS-1:0]     slot_next [TQ_CAPACITY];
  logic [SLOT_BITS-1:0]     lead      [TQ_TEAMS];
  logic [SLOT_BITS-1:0]     last      [TQ_TEAMS];
  logic                     queued    [TQ_TEAMS];
  logic [TQ_TEAM_BITS-1:0]  rota      [TQ_TEAMS];
  logic [TQ_TEAM_BITS-1:0]  rota_rd, rota_wr;
  logic [TQ_ORDER_BITS-1:0] rota_fill;
  logic [SLOT_BITS:0]       fresh, free_len, held;
  logic [SLOT_BITS-1:0]     free_top;

  tq_out_t due_results[$];
  int      seen;

  function automatic tq_out_t serve_op(input tq_in_t it);
    tq_out_t                 r;
    logic [SLOT_BITS-1:0]    s;
    logic [TQ_TEAM_BITS-1:0] t;
    r = '0;
    r.status = STATUS_DONE;
    if (tq_op_t'(it.mode) == OP_ENQ) begin
      t = it.team;
      if (held >= TQ_CAPACITY) begin
        r.status = STATUS_FULL;
      end else begin
        if (free_len != 0) begin
          s = free_top;
          free_top = slot_next[s];
          free_len--;
        end else begin
          s = fresh[SLOT_BITS-1:0];
          fresh++;
        end
        slot_val[s] = it.value;
        slot_next[s] = '0;
        if (queued[t]) begin
          slot_next[last[t]] = s;
          last[t] = s;
        end else begin
          lead[t] = s;
          last[t] = s;
          queued[t] = 1'b1;
          rota[rota_wr] = t;
          rota_wr++;
          rota_fill++;
        end
        held++;
      end
    end else if (rota_fill == 0) begin
      r.status = STATUS_EMPTY;
    end else begin
      t = rota[rota_rd];
      s = lead[t];
      r.out_team = t;
      r.out_value = slot_val[s];
      if (s == last[t]) begin
        queued[t] = 1'b0;
        rota_rd++;
        rota_fill--;
      end else begin
        lead[t] = slot_next[s];
      end
      slot_next[s] = free_top;
      free_top = s;
      free_len++;
      if (held != 0) held--;
    end
    r.now_empty = (held == 0);
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch in %s, result transaction %0d: got 0x%0h, expected 0x%0h",
             field, seen, got, want);
    errors++;
  endtask

  initial begin
    errors = 0;
    pending = 0;
    seen = 0;
  end

  always @(posedge clk) begin
    tq_out_t want;
    if (rst) begin
      for (int i = 0; i < TQ_TEAMS; i++) begin
        queued[i] = 1'b0;
        lead[i] = '0;
        last[i] = '0;
      end
      rota_rd = '0;
      rota_wr = '0;
      rota_fill = '0;
      fresh = '0;
      free_len = '0;
      free_top = '0;
      held = '0;
      due_results.delete();
    end else begin
      if (pop && !empty) begin
        if (due_results.size() == 0) begin
          report_mismatch("unexpected transaction", 32'(result), 32'd0);
        end else begin
          want = due_results[0];
          due_results.delete(0);
          if (result.status !== want.status)
            report_mismatch("status", 32'(result.status), 32'(want.status));
          if (result.out_team !== want.out_team)
            report_mismatch("out_team", 32'(result.out_team), 32'(want.out_team));
          if (result.out_value !== want.out_value)
            report_mismatch("out_value", 32'(result.out_value), 32'(want.out_value));
          if (result.now_empty !== want.now_empty)
            report_mismatch("now_empty", 32'(result.now_empty), 32'(want.now_empty));
        end
        seen++;
      end
      if (push && !full) due_results.insert(due_results.size(), serve_op(item));
    end
    pending = due_results.size();
  end

endmodule

### sim/team_queue_tb.sv
// team_queue_tb: drives enqueue/dequeue transactions into team_queue with
// bursty input and a patterned result stall; team_queue_chk does the checking.
// Depends on tq_pkg, team_queue, team_queue_chk.
module team_queue_tb;
  import tq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 425;
  localparam int HOLD_CYCLES  = 80;
  localparam int LIMIT        = 400000;

  logic    clk;
  logic    rst;
  logic    push;
  logic    full;
  tq_in_t  item;
  logic    empty;
  logic    pop;
  tq_out_t result;
  int      errors;
  int      pending;
  logic    hold_req;
  int      burst_left;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  team_queue i_dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  team_queue_chk i_chk (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .item    (item),
    .empty   (empty),
    .pop     (pop),
    .result  (result),
    .errors  (errors),
    .pending (pending)
  );

  task automatic send_item(input tq_op_t op, input logic [TQ_TEAM_BITS-1:0] tm,
                           input logic [TQ_VALUE_BITS-1:0] v);
    tq_in_t it;
    int     gap;
    it.mode = op;
    it.team = tm;
    it.value = v;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        @(negedge clk);
        push <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    @(negedge clk);
    push <= 1'b1;
    item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic send_deq();
    send_item(OP_DEQ, 4'($urandom), 16'($urandom));
  endtask

  // result side: rotating stall pattern, plus a long hold-off on request
  initial begin
    logic [7:0] pat;
    int         span;
    pop = 1'b0;
    pat = 8'hFF;
    span = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        if (span == 0) begin
          span = $urandom_range(16, 96);
          pat = ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
        end
        span--;
        pop <= pat[0];
        pat = {pat[0], pat[7:1]};
      end
    end
  end

  initial begin
    repeat (LIMIT) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int                      enq_pct;
    logic                    narrow;
    logic [TQ_TEAM_BITS-1:0] base;
    logic [TQ_TEAM_BITS-1:0] tm;
    rst = 1'b1;
    push = 1'b0;
    item = '0;
    hold_req = 1'b0;
    burst_left = 0;
    enq_pct = 50;
    narrow = 1'b0;
    base = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty dequeue, field extremes, interleaved teams, team rejoining
    send_deq();
    send_item(OP_ENQ, 4'd0, 16'h0000);
    send_item(OP_ENQ, 4'd15, 16'hFFFF);
    send_item(OP_ENQ, 4'd0, 16'h1234);
    send_item(OP_ENQ, 4'd7, 16'h8000);
    send_item(OP_ENQ, 4'd15, 16'h0001);
    repeat (6) send_deq();
    send_item(OP_ENQ, 4'd5, 16'hA5A5);
    send_deq();
    send_item(OP_ENQ, 4'd5, 16'h5A5A);
    send_item(OP_ENQ, 4'd10, 16'h7FFF);
    send_item(OP_ENQ, 4'd5, 16'hC3C3);
    send_item(OP_ENQ, 4'd10, 16'h0F0F);
    repeat (5) send_deq();

    // random mix; the enqueue share drifts so the queue grows and drains
    hold_req = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: enq_pct = 25;
          1: enq_pct = 50;
          default: enq_pct = 80;
        endcase
        narrow = 1'($urandom);
        base = 4'($urandom);
      end
      tm = narrow ? 4'(base + $urandom_range(0, 2)) : 4'($urandom);
      if ($urandom_range(0, 99) < enq_pct) send_item(OP_ENQ, tm, 16'($urandom));
      else send_deq();
    end

    @(negedge clk);
    push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (12) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### files.f
rtl/tq_pkg.sv
rtl/tq_ram.sv
rtl/tq_fifo.sv
rtl/tq_front.sv
rtl/tq_back.sv
rtl/team_queue.sv
rtl/tq_checker.sv
sim/team_queue_chk.sv
sim/team_queue_tb.sv
